>>> src/sacl_pkg.sv
// Shared types, constants and helper functions for the cache tag lookup unit.
// Used by sacl_ctrl, sacl_dpath and the top level; depends on nothing.
package sacl_pkg;

  // Default geometry of the tag store
  localparam int DEF_MAX_SETS   = 1024;
  localparam int DEF_MAX_WAYS   = 8;
  localparam int DEF_LINE_BYTES = 16;
  localparam int DEF_ADDR_WIDTH = 32;

  // Configuration port layout
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS = 2'd2;

  // Register reset values
  localparam logic             RST_POLICY     = 1'b0;
  localparam logic [CFG_W-1:0] RST_WAYS       = 4'd1;
  localparam logic [CFG_W-1:0] RST_INDEX_BITS = 4'd6;

  // Replacement policy code
  localparam logic POL_LRU = 1'b0;

  // Age rank per way, 0 is oldest
  localparam int RANK_W = 3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } sacl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_en;     // write the initial metadata row at the clear counter
    logic lookup_en;  // capture address, read the set's rows
    logic commit;     // write back the set and load the result register
  } sacl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;   // clear counter is at the last set
  } sacl_sts_t;

  // Floor of log2, for elaboration-time geometry
  function automatic int floor_log2(input int v);
    int n;
    n = 0;
    for (int i = 1; i < 31; i++) begin
      if ((v >> i) != 0) n = i;
    end
    return n;
  endfunction

endpackage

>>> src/sacl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sacl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/sacl_ctrl.sv
// Controller FSM of the cache tag lookup unit: clearing pass, accept, lookup.
// Depends on sacl_pkg.
module sacl_ctrl import sacl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  sacl_sts_t sts_i,
  output sacl_cmd_t cmd_o
);

  sacl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_hold;

  // Previous result still waiting downstream
  assign out_hold = out_valid_q & out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_LOOKUP;
      ST_LOOKUP: if (!out_hold) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    cmd_o.clr_en    = (state_q == ST_CLEAR);
    cmd_o.lookup_en = (state_q == ST_IDLE) & in_valid_i;
    cmd_o.commit    = (state_q == ST_LOOKUP) & !out_hold;
    in_stall_o      = (state_q != ST_IDLE);
  end

  // Output beat: set on commit, drop when taken
  assign out_valid_d = cmd_o.commit | out_hold;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Accepted beat moves to lookup
  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.lookup_en |=> (state_q == ST_LOOKUP))
    else $error("accepted beat did not enter lookup");

  // Lookup waits while the previous result is held
  a_lookup_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) && out_hold |=> (state_q == ST_LOOKUP))
    else $error("lookup finished over an unaccepted result");

  // Commit always presents a result
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("commit without output beat");

endmodule

>>> src/sacl_dpath.sv
// Datapath of the cache tag lookup unit: address split, tag and metadata RAMs,
// hit detection, victim choice, age update and result register. Uses sacl_pkg, sacl_ram.
module sacl_dpath import sacl_pkg::*; #(
  parameter int MAX_SETS   = DEF_MAX_SETS,
  parameter int MAX_WAYS   = DEF_MAX_WAYS,
  parameter int LINE_BYTES = DEF_LINE_BYTES,
  parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sacl_cmd_t             cmd_i,
  output sacl_sts_t             sts_o,
  input  logic [ADDR_WIDTH-1:0] in_address_i,
  input  logic                  policy_i,
  input  logic [CFG_W-1:0]      ways_i,
  input  logic [CFG_W-1:0]      index_bits_i,
  output logic                  out_is_miss_o
);

  localparam int OFF_BITS = floor_log2(LINE_BYTES);
  localparam int IB_MAX   = floor_log2(MAX_SETS);
  localparam int SET_W    = (IB_MAX > 0) ? IB_MAX : 1;
  localparam int DEPTH    = 1 << IB_MAX;
  localparam int TAG_W    = ADDR_WIDTH - OFF_BITS;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int META_W   = MAX_WAYS + MAX_WAYS * RANK_W;
  localparam int TROW_W   = MAX_WAYS * TAG_W;
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(DEPTH - 1);

  typedef logic [MAX_WAYS-1:0][RANK_W-1:0] rank_row_t;
  typedef logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_row_t;

  // Effective configuration
  logic [CFG_W-1:0] nways, ib;
  always_comb begin
    if (ways_i == '0)                       nways = CFG_W'(1);
    else if (ways_i > CFG_W'(MAX_WAYS))     nways = CFG_W'(MAX_WAYS);
    else                                    nways = ways_i;
    ib = (index_bits_i > CFG_W'(IB_MAX)) ? CFG_W'(IB_MAX) : index_bits_i;
  end

  // Split the incoming address into set and tag
  logic [TAG_W-1:0]       line_addr, tag_in;
  logic [TAG_W+SET_W-1:0] line_ext;
  logic [SET_W-1:0]       set_in;
  assign line_addr = in_address_i[ADDR_WIDTH-1:OFF_BITS];
  assign line_ext  = {{SET_W{1'b0}}, line_addr};
  assign set_in    = line_ext[SET_W-1:0] & ~({SET_W{1'b1}} << ib);
  assign tag_in    = line_addr >> ib;

  // Hold set and tag of the beat in flight
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup_en) begin
      set_q <= set_in;
      tag_q <= tag_in;
    end
  end

  // Advance the clear counter
  logic [SET_W-1:0] clr_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end
  assign sts_o.clr_last = (clr_cnt_q == LAST_SET);

  // RAM rows
  logic [META_W-1:0] meta_rd, meta_wd;
  logic [TROW_W-1:0] tag_rd;
  logic [SET_W-1:0]  meta_waddr;
  logic              meta_we;
  logic              tag_we;

  logic [MAX_WAYS-1:0] valid_r, valid_n;
  rank_row_t           rank_r, rank_n, rank_init;
  tag_row_t            tag_r, tag_n;

  assign valid_r = meta_rd[MAX_WAYS-1:0];
  assign rank_r  = meta_rd[META_W-1:MAX_WAYS];
  assign tag_r   = tag_rd;

  // Lookup, victim choice and age update
  logic [MAX_WAYS-1:0] in_use, match;
  logic                hit, found_inv, upd, is_miss_n;
  logic [WAY_W-1:0]    hit_way, inv_way, old_way, way;
  logic [RANK_W-1:0]   min_rank, old_rank;

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    found_inv = 1'b0;
    inv_way   = '0;
    old_way   = '0;
    min_rank  = rank_r[0];
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = nways > CFG_W'(w);
      match[w]  = in_use[w] & valid_r[w] & (tag_r[w] == tag_q);
    end
    // First matching way
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (match[w] && !hit) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
    // First invalid way in use
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && !valid_r[w] && !found_inv) begin
        found_inv = 1'b1;
        inv_way   = WAY_W'(w);
      end
    end
    // Oldest way in use, lowest number on ties
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && (rank_r[w] < min_rank)) begin
        min_rank = rank_r[w];
        old_way  = WAY_W'(w);
      end
    end
    is_miss_n = !hit;
    if (hit)            way = hit_way;
    else if (found_inv) way = inv_way;
    else                way = old_way;
    upd      = is_miss_n | (policy_i == POL_LRU);
    old_rank = rank_r[way];

    // Make the chosen way newest, on a miss or under LRU
    for (int v = 0; v < MAX_WAYS; v++) begin
      rank_n[v] = rank_r[v];
      if (upd && in_use[v] && (WAY_W'(v) != way) && (rank_r[v] > old_rank)) begin
        rank_n[v] = rank_r[v] - 1'b1;
      end
    end
    if (upd) rank_n[way] = RANK_W'(nways - 1'b1);

    // Fill the victim on a miss
    valid_n = valid_r;
    tag_n   = tag_r;
    if (is_miss_n) begin
      valid_n[way] = 1'b1;
      tag_n[way]   = tag_q;
    end
  end

  // Initial metadata row: ranks follow way numbers, nothing valid
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      rank_init[w] = RANK_W'(w);
    end
  end

  assign meta_we    = cmd_i.clr_en | cmd_i.commit;
  assign meta_waddr = cmd_i.clr_en ? clr_cnt_q : set_q;
  assign meta_wd    = cmd_i.clr_en ? {rank_init, {MAX_WAYS{1'b0}}} : {rank_n, valid_n};
  assign tag_we     = cmd_i.commit & is_miss_n;

  sacl_ram #(
    .WIDTH (META_W),
    .DEPTH (DEPTH)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wd),
    .re_i    (cmd_i.lookup_en),
    .raddr_i (set_in),
    .rdata_o (meta_rd)
  );

  sacl_ram #(
    .WIDTH (TROW_W),
    .DEPTH (DEPTH)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (set_q),
    .wdata_i (tag_n),
    .re_i    (cmd_i.lookup_en),
    .raddr_i (set_in),
    .rdata_o (tag_rd)
  );

  // Result register
  logic is_miss_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) is_miss_q <= is_miss_n;
  end
  assign out_is_miss_o = is_miss_q;

  // A lookup never clears a valid bit
  a_valid_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> ((valid_n & valid_r) == valid_r))
    else $error("valid bit lost on write-back");

  // The victim of a miss is a way in use
  a_victim_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && is_miss_n |-> (CFG_W'(way) < nways))
    else $error("victim outside the ways in use");

endmodule

>>> src/set_assoc_cache_tag_lookup_unit.sv
// Top level of the set-associative cache tag lookup unit: configuration
// registers, controller and datapath. Depends on sacl_pkg, sacl_ctrl, sacl_dpath.
//
// Each address beat first gets the registered read of the set's tag row and
// metadata row (valid bits and age ranks), then tag compare, victim choice,
// age update and write-back (tag row only on a miss); no new beat is taken
// until the previous one is written back. The result register lets the next
// beat be taken while a result waits; a lookup holds before write-back until
// the previous result has been taken. After reset the unit clears the metadata
// RAM one set per cycle, all 2**floor(log2(MAX_SETS)) sets (1024 by default),
// and stalls the input meanwhile; configuration writes are taken at any time
// but belong between beats. Register changes keep all lines and ranks.
module set_assoc_cache_tag_lookup_unit import sacl_pkg::*; #(
  parameter int MAX_SETS   = DEF_MAX_SETS,
  parameter int MAX_WAYS   = DEF_MAX_WAYS,
  parameter int LINE_BYTES = DEF_LINE_BYTES,
  parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ADDR_WIDTH-1:0] in_address_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  out_is_miss_o
);

  logic             policy_q;
  logic [CFG_W-1:0] ways_q;
  logic [CFG_W-1:0] index_bits_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q     <= RST_POLICY;
      ways_q       <= RST_WAYS;
      index_bits_q <= RST_INDEX_BITS;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_POLICY:     policy_q     <= cfg_data_i[0];
        REG_WAYS:       ways_q       <= cfg_data_i;
        REG_INDEX_BITS: index_bits_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sacl_cmd_t cmd;
  sacl_sts_t sts;

  sacl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sacl_dpath #(
    .MAX_SETS   (MAX_SETS),
    .MAX_WAYS   (MAX_WAYS),
    .LINE_BYTES (LINE_BYTES),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_address_i  (in_address_i),
    .policy_i      (policy_q),
    .ways_i        (ways_q),
    .index_bits_i  (index_bits_q),
    .out_is_miss_o (out_is_miss_o)
  );

endmodule
